[design/sstp_pkg.sv]
// Package: shared types and constants of the step start-time placer.
`timescale 1ns / 1ps
package sstp_pkg;
    localparam int NumRes   = 8;
    localparam int ResW     = $clog2(NumRes);
    localparam int MaxSteps = 256;
    localparam int SlotW    = $clog2(MaxSteps);
    localparam int CntW     = SlotW + 1;
    localparam int DepW     = 9;
    localparam int TimeW    = 32;
    localparam int ExtW     = TimeW + 2;

    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_ABORTED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DEP_RD, S_DEP_CHK, S_RES, S_COOL,
        S_PASS_START, S_SCAN_RD, S_SCAN_CHK, S_PASS_END, S_COMMIT, S_OUT
    } state_t;

    typedef struct packed {
        logic [SlotW-1:0] slot;
        logic [ResW-1:0]  res;
        logic [TimeW-1:0] dur;
        logic [DepW-1:0]  dep_a;
        logic [DepW-1:0]  dep_b;
        logic [DepW-1:0]  dep_c;
        logic [DepW-1:0]  dep_d;
        logic [TimeW-1:0] settle;
        logic [TimeW-1:0] cool;
        logic [TimeW-1:0] limit;
        logic [NumRes-1:0] mask;
        logic             new_sched;
    } step_t;

    typedef struct packed {
        logic             we;
        logic [SlotW-1:0] addr;
        logic [TimeW-1:0] wdata;
    } end_wr_t;

    typedef struct packed {
        logic             we;
        logic [SlotW-1:0] addr;
        logic [TimeW-1:0] s;
        logic [TimeW-1:0] e;
        logic [ResW-1:0]  owner;
    } ivl_wr_t;
endpackage

[design/sstp_end_store.sv]
// Module: per-slot end-time memory with done bits.
`timescale 1ns / 1ps
module sstp_end_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clr,
    input  sstp_pkg::end_wr_t             wr,
    input  logic [sstp_pkg::SlotW-1:0]    raddr,
    output logic [sstp_pkg::TimeW-1:0]    rdata,
    output logic                          rdone
);
    logic [sstp_pkg::TimeW-1:0] mem [sstp_pkg::MaxSteps];
    logic [sstp_pkg::MaxSteps-1:0] done_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            done_reg <= '0;
            rdone    <= 1'b0;
        end else begin
            if (wr.we) begin
                done_reg[wr.addr] <= 1'b1;
            end
            rdone <= done_reg[raddr];
        end
    end
endmodule

[design/sstp_ivl_store.sv]
// Module: placed-interval memory, appended in order.
`timescale 1ns / 1ps
module sstp_ivl_store (
    input  logic                          aclk,
    input  sstp_pkg::ivl_wr_t             wr,
    input  logic [sstp_pkg::SlotW-1:0]    raddr,
    output logic [sstp_pkg::TimeW-1:0]    rs,
    output logic [sstp_pkg::TimeW-1:0]    re,
    output logic [sstp_pkg::ResW-1:0]     rowner
);
    localparam int W = 2 * sstp_pkg::TimeW + sstp_pkg::ResW;
    logic [W-1:0] mem [sstp_pkg::MaxSteps];
    logic [W-1:0] rd;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= {wr.owner, wr.e, wr.s};
        end
        rd <= mem[raddr];
    end

    assign rs     = rd[sstp_pkg::TimeW-1:0];
    assign re     = rd[2*sstp_pkg::TimeW-1:sstp_pkg::TimeW];
    assign rowner = rd[W-1:2*sstp_pkg::TimeW];
endmodule

[design/step_start_time_placer_core.sv]
// Module: top level of the step start-time placer.
`timescale 1ns / 1ps
// Usage:
//   s_ channel carries one step request; m_ channel returns one result per request.
//   cfg channel writes step_count while the block is idle and no result is waiting.
//   One request at a time: s_tready is high only in the idle state.
//   A request runs through the dependency checks and the resource check, then through
//   scan passes over the stored intervals (pushing passes plus the final clean one);
//   a new_schedule request adds a clear state, and a resource that is active with a
//   duty limit adds a cooldown check. The next request is taken back in the idle state.
//   These steps share the 34-bit compare/add unit and the single interval read port.
//   A new_schedule request clears the resource table and the done bits together
//   in the clear state; the interval memory needs no clearing pass (fill count guards it).
//   Reset clears all control state and sets step_count to 256.
//   When the receiver stalls, the result is held in the output register; the next
//   request is still taken and computed, then held until the output register frees.
//   Output tdata: out_slot, start_time, end_time, status from bit 0 up.
module step_start_time_placer_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_slot, resource_num, step_len_ms, dep_a, dep_b, dep_c, dep_d,
    // settle_ms, cool_gap_ms, duty_limit_ms, partner_mask, new_schedule
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_slot, start_time, end_time, status
    output logic [79:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);
    localparam int TW = sstp_pkg::TimeW;
    localparam int XW = sstp_pkg::ExtW;
    localparam int NR = sstp_pkg::NumRes;
    localparam int SW = sstp_pkg::SlotW;
    localparam int CW = sstp_pkg::CntW;
    localparam logic [XW-1:0] TMax = {2'b00, {TW{1'b1}}};

    sstp_pkg::state_t state_reg, state_next;
    sstp_pkg::step_t  st_reg, st_next;

    logic [8:0]    count_reg;
    logic [XW-1:0] start_reg, start_next;
    logic [XW-1:0] pstart_reg, pstart_next;
    logic          pushed_reg, pushed_next;
    logic [CW-1:0] guard_reg, guard_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    dsel_reg, dsel_next;
    logic [CW-1:0] pcount_reg, pcount_next;
    logic          failed_reg, failed_next;
    logic          mval_reg, mval_next;
    logic [79:0]   mdat_reg, mdat_next;
    logic [79:0]   rslt_reg, rslt_next;

    logic          act_reg  [NR];
    logic [TW-1:0] last_reg [NR];
    logic [TW-1:0] run_reg  [NR];
    logic          hit_reg  [NR];
    logic          res_we, res_clr;

    sstp_pkg::end_wr_t ewr;
    sstp_pkg::ivl_wr_t iwr;
    logic [SW-1:0]  eraddr;
    logic [TW-1:0]  erdata;
    logic           erdone;
    logic [TW-1:0]  ivs, ive;
    logic [sstp_pkg::ResW-1:0] ivo;
    logic           clr_done;

    // shared unit: one 34-bit add and one compare
    logic [XW-1:0] au_a, au_b, au_sum, cu_a, cu_b;
    logic          cu_gt;
    assign au_sum = au_a + au_b;
    assign cu_gt  = cu_a > cu_b;

    sstp_pkg::step_t s_unp;
    always_comb begin
        s_unp.slot      = s_tdata[7:0];
        s_unp.res       = s_tdata[10:8];
        s_unp.dur       = s_tdata[42:11];
        s_unp.dep_a     = s_tdata[51:43];
        s_unp.dep_b     = s_tdata[60:52];
        s_unp.dep_c     = s_tdata[69:61];
        s_unp.dep_d     = s_tdata[78:70];
        s_unp.settle    = s_tdata[110:79];
        s_unp.cool      = s_tdata[142:111];
        s_unp.limit     = s_tdata[174:143];
        s_unp.mask      = s_tdata[182:175];
        s_unp.new_sched = s_tdata[183];
    end

    sstp_end_store u_end (
        .aclk(aclk), .aresetn(aresetn), .clr(clr_done), .wr(ewr),
        .raddr(eraddr), .rdata(erdata), .rdone(erdone)
    );

    sstp_ivl_store u_ivl (
        .aclk(aclk), .wr(iwr), .raddr(idx_reg[SW-1:0]),
        .rs(ivs), .re(ive), .rowner(ivo)
    );

    assign s_tready  = (state_reg == sstp_pkg::S_IDLE);
    assign cfg_ready = (state_reg == sstp_pkg::S_IDLE) && !mval_reg;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = mdat_reg;

    logic [sstp_pkg::DepW-1:0] dep_cur;
    always_comb begin
        unique case (dsel_reg)
            2'd0: dep_cur = st_reg.dep_a;
            2'd1: dep_cur = st_reg.dep_b;
            2'd2: dep_cur = st_reg.dep_c;
            default: dep_cur = st_reg.dep_d;
        endcase
    end
    assign eraddr = dep_cur[SW-1:0];

    logic [XW-1:0] last_x, dur_x, gap_x, run_x;
    logic          exceed, run_ge;
    assign last_x = {2'b00, last_reg[st_reg.res]};
    assign dur_x  = {2'b00, st_reg.dur};
    assign gap_x  = start_reg - last_x;
    assign run_x  = ({2'b00, run_reg[st_reg.res]} + dur_x);
    assign exceed = run_x > {2'b00, st_reg.limit};

    logic [NR-1:0] emask;
    always_comb begin
        emask = st_reg.mask;
        emask[st_reg.res] = 1'b0;
    end

    always_comb begin
        state_next  = state_reg;
        st_next     = st_reg;
        start_next  = start_reg;
        pstart_next = pstart_reg;
        pushed_next = pushed_reg;
        guard_next  = guard_reg;
        idx_next    = idx_reg;
        dsel_next   = dsel_reg;
        pcount_next = pcount_reg;
        failed_next = failed_reg;
        mval_next   = mval_reg;
        mdat_next   = mdat_reg;
        rslt_next   = rslt_reg;
        res_we      = 1'b0;
        res_clr     = 1'b0;
        clr_done    = 1'b0;
        ewr         = '0;
        iwr         = '0;
        au_a        = start_reg;
        au_b        = dur_x;
        cu_a        = '0;
        cu_b        = '0;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            sstp_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    st_next    = s_unp;
                    start_next = '0;
                    dsel_next  = 2'd0;
                    state_next = s_unp.new_sched ? sstp_pkg::S_CLEAR : sstp_pkg::S_DEP_RD;
                end
            end
            sstp_pkg::S_CLEAR: begin
                res_clr     = 1'b1;
                clr_done    = 1'b1;
                pcount_next = '0;
                failed_next = 1'b0;
                state_next  = sstp_pkg::S_DEP_RD;
            end
            sstp_pkg::S_DEP_RD: begin
                if (failed_reg) begin
                    rslt_next  = {6'd0, sstp_pkg::ST_ABORTED, 64'd0, st_reg.slot};
                    state_next = sstp_pkg::S_OUT;
                end else begin
                    state_next = sstp_pkg::S_DEP_CHK;
                end
            end
            sstp_pkg::S_DEP_CHK: begin
                cu_a = {2'b00, erdata};
                cu_b = start_reg;
                if (!dep_cur[SW] && erdone && cu_gt) begin
                    start_next = cu_a;
                end
                dsel_next  = dsel_reg + 2'd1;
                state_next = (dsel_reg == 2'd3) ? sstp_pkg::S_RES : sstp_pkg::S_DEP_RD;
            end
            sstp_pkg::S_RES: begin
                au_a = last_x;
                au_b = {2'b00, st_reg.settle};
                cu_a = au_sum;
                cu_b = start_reg;
                if (act_reg[st_reg.res] && cu_gt) begin
                    start_next = au_sum;
                end
                state_next = (act_reg[st_reg.res] && st_reg.limit != '0)
                           ? sstp_pkg::S_COOL : sstp_pkg::S_PASS_START;
            end
            sstp_pkg::S_COOL: begin
                au_a = last_x;
                au_b = {2'b00, st_reg.cool};
                cu_a = au_sum;
                cu_b = start_reg;
                if (gap_x < {2'b00, st_reg.cool} && (hit_reg[st_reg.res] || exceed)
                    && cu_gt) begin
                    start_next = au_sum;
                end
                state_next = sstp_pkg::S_PASS_START;
            end
            sstp_pkg::S_PASS_START: begin
                pstart_next = start_reg;
                pushed_next = 1'b0;
                idx_next    = '0;
                state_next  = (pcount_reg == '0) ? sstp_pkg::S_PASS_END
                                                 : sstp_pkg::S_SCAN_RD;
            end
            sstp_pkg::S_SCAN_RD: begin
                state_next = sstp_pkg::S_SCAN_CHK;
            end
            sstp_pkg::S_SCAN_CHK: begin
                au_a = pstart_reg;
                cu_a = {2'b00, ive};
                cu_b = start_reg;
                if (emask[ivo] && pstart_reg < {2'b00, ive} && {2'b00, ivs} < au_sum) begin
                    pushed_next = 1'b1;
                    if (cu_gt) begin
                        start_next = cu_a;
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == pcount_reg) ? sstp_pkg::S_PASS_END
                                                            : sstp_pkg::S_SCAN_RD;
            end
            sstp_pkg::S_PASS_END: begin
                if (pushed_reg) begin
                    guard_next = guard_reg + 1'b1;
                    if ({1'b0, guard_reg} + 1'b1 > {1'b0, count_reg} + 10'd1) begin
                        failed_next = 1'b1;
                        rslt_next   = {6'd0, sstp_pkg::ST_CONFLICT, 64'd0, st_reg.slot};
                        state_next  = sstp_pkg::S_OUT;
                    end else begin
                        state_next = sstp_pkg::S_PASS_START;
                    end
                end else begin
                    state_next = sstp_pkg::S_COMMIT;
                end
            end
            sstp_pkg::S_COMMIT: begin
                cu_a = au_sum;
                cu_b = TMax;
                if (cu_gt) begin
                    failed_next = 1'b1;
                    rslt_next   = {6'd0, sstp_pkg::ST_OVERFLOW, 64'd0, st_reg.slot};
                end else begin
                    ewr.we      = 1'b1;
                    ewr.addr    = st_reg.slot;
                    ewr.wdata   = au_sum[TW-1:0];
                    res_we      = 1'b1;
                    if (pcount_reg != CW'(sstp_pkg::MaxSteps)) begin
                        iwr.we      = 1'b1;
                        iwr.addr    = pcount_reg[SW-1:0];
                        iwr.s       = start_reg[TW-1:0];
                        iwr.e       = au_sum[TW-1:0];
                        iwr.owner   = st_reg.res;
                        pcount_next = pcount_reg + 1'b1;
                    end
                    rslt_next = {6'd0, sstp_pkg::ST_PLACED, au_sum[TW-1:0],
                                 start_reg[TW-1:0], st_reg.slot};
                end
                state_next = sstp_pkg::S_OUT;
            end
            sstp_pkg::S_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdat_next  = rslt_reg;
                    guard_next = '0;
                    state_next = sstp_pkg::S_IDLE;
                end
            end
            default: state_next = sstp_pkg::S_IDLE;
        endcase
    end

    // resource table update
    logic [XW-1:0] gap_c, runc;
    logic          reset_run;
    always_comb begin
        gap_c     = start_reg - last_x;
        reset_run = !act_reg[st_reg.res] || gap_c >= {2'b00, st_reg.cool};
        runc      = (reset_run ? '0 : {2'b00, run_reg[st_reg.res]}) + dur_x;
        if (runc > TMax) begin
            runc = TMax;
        end
    end
    assign run_ge = runc >= {2'b00, st_reg.limit};

    always_ff @(posedge aclk) begin
        if (!aresetn || res_clr) begin
            for (int k = 0; k < NR; k++) begin
                act_reg[k]  <= 1'b0;
                last_reg[k] <= '0;
                run_reg[k]  <= '0;
                hit_reg[k]  <= 1'b0;
            end
        end else if (res_we) begin
            act_reg[st_reg.res]  <= 1'b1;
            last_reg[st_reg.res] <= au_sum[TW-1:0];
            if (st_reg.limit != '0) begin
                run_reg[st_reg.res] <= runc[TW-1:0];
                hit_reg[st_reg.res] <= run_ge;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sstp_pkg::S_IDLE;
            count_reg  <= 9'd256;
            guard_reg  <= '0;
            pcount_reg <= '0;
            failed_reg <= 1'b0;
            mval_reg   <= 1'b0;
            idx_reg    <= '0;
            dsel_reg   <= '0;
            pushed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            guard_reg  <= guard_next;
            pcount_reg <= pcount_next;
            failed_reg <= failed_next;
            mval_reg   <= mval_next;
            idx_reg    <= idx_next;
            dsel_reg   <= dsel_next;
            pushed_reg <= pushed_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg     <= st_next;
        start_reg  <= start_next;
        pstart_reg <= pstart_next;
        mdat_reg   <= mdat_next;
        rslt_reg   <= rslt_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sstp_pkg::S_IDLE) |-> !s_tready)
        else $error("request taken while busy");
    a_pcount_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg <= CW'(sstp_pkg::MaxSteps))
        else $error("interval count overrun");
    a_out_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sstp_pkg::S_OUT && !mval_reg) |=> mval_reg)
        else $error("result not raised");
endmodule

[verif/testbench.sv]
// Testbench: step start-time placer core checked against its own placement predictor.
`timescale 1ns / 1ps
module testbench;
    localparam int SLW = sstp_pkg::SlotW;
    localparam int RW  = sstp_pkg::ResW;
    localparam int DW  = sstp_pkg::DepW;
    localparam int MW  = sstp_pkg::NumRes;

    typedef struct packed {
        logic [1:0]                 status;
        logic [sstp_pkg::TimeW-1:0] fin;
        logic [sstp_pkg::TimeW-1:0] start;
        logic [sstp_pkg::SlotW-1:0] slot;
    } placement_t;

    localparam logic [sstp_pkg::DepW-1:0] NO_DEP = 9'd256;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [8:0]   cfg_data = '0;

    placement_t   pending_placements[$];
    int           errors = 0;
    int           hold_cycles = 0;
    bit           calm = 1'b0;

    // predictor state
    logic [8:0]                 pr_step_count;
    bit                         pr_active[sstp_pkg::NumRes];
    logic [sstp_pkg::TimeW-1:0] pr_last_end[sstp_pkg::NumRes];
    logic [sstp_pkg::TimeW-1:0] pr_run_time[sstp_pkg::NumRes];
    bit                         pr_limit_hit[sstp_pkg::NumRes];
    logic [sstp_pkg::TimeW-1:0] pr_step_end[sstp_pkg::MaxSteps];
    bit                         pr_step_done[sstp_pkg::MaxSteps];
    logic [sstp_pkg::TimeW-1:0] pr_ivl_start[sstp_pkg::MaxSteps];
    logic [sstp_pkg::TimeW-1:0] pr_ivl_end[sstp_pkg::MaxSteps];
    logic [sstp_pkg::ResW-1:0]  pr_ivl_owner[sstp_pkg::MaxSteps];
    int                         pr_ivl_count;
    bit                         pr_failed;

    step_start_time_placer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void wipe_schedule();
        for (int i = 0; i < sstp_pkg::NumRes; i++) begin
            pr_active[i] = 0;
            pr_last_end[i] = '0;
            pr_run_time[i] = '0;
            pr_limit_hit[i] = 0;
        end
        for (int i = 0; i < sstp_pkg::MaxSteps; i++) pr_step_done[i] = 0;
        pr_ivl_count = 0;
        pr_failed = 0;
    endfunction

    function automatic placement_t place_step(sstp_pkg::step_t s);
        placement_t                  p;
        logic [63:0]                 start, fin, gap, run, cs, ce, last;
        logic [sstp_pkg::DepW-1:0]   deps[4];
        logic [sstp_pkg::NumRes-1:0] mask;
        int                          passes;
        bit                          pushed, exceed;
        p.slot = s.slot;
        p.start = '0;
        p.fin = '0;
        p.status = sstp_pkg::ST_PLACED;
        if (s.new_sched) wipe_schedule();
        if (pr_failed) begin
            p.status = sstp_pkg::ST_ABORTED;
            return p;
        end
        deps = '{s.dep_a, s.dep_b, s.dep_c, s.dep_d};
        start = 0;
        foreach (deps[i])
            if (deps[i] < sstp_pkg::MaxSteps && pr_step_done[deps[i]] &&
                pr_step_end[deps[i]] > start)
                start = pr_step_end[deps[i]];
        if (pr_active[s.res]) begin
            last = pr_last_end[s.res];
            if (last + s.settle > start) start = last + s.settle;
            if (s.limit != 0) begin
                gap = start - last;
                exceed = 64'(pr_run_time[s.res]) + s.dur > s.limit;
                if (gap < s.cool && (pr_limit_hit[s.res] || exceed) && last + s.cool > start)
                    start = last + s.cool;
            end
        end
        mask = s.mask;
        mask[s.res] = 1'b0;
        passes = 0;
        pushed = 1;
        while (pushed) begin
            cs = start;
            ce = start + s.dur;
            pushed = 0;
            for (int i = 0; i < pr_ivl_count; i++)
                if (mask[pr_ivl_owner[i]] && cs < pr_ivl_end[i] && pr_ivl_start[i] < ce) begin
                    if (pr_ivl_end[i] > start) start = pr_ivl_end[i];
                    pushed = 1;
                end
            if (pushed) begin
                passes++;
                if (passes > int'(pr_step_count) + 1) begin
                    pr_failed = 1;
                    p.status = sstp_pkg::ST_CONFLICT;
                    return p;
                end
            end
        end
        fin = start + s.dur;
        if (fin > 64'hFFFF_FFFF) begin
            pr_failed = 1;
            p.status = sstp_pkg::ST_OVERFLOW;
            return p;
        end
        pr_step_end[s.slot] = fin[31:0];
        pr_step_done[s.slot] = 1;
        if (s.limit != 0) begin
            gap = start - pr_last_end[s.res];
            if (!pr_active[s.res] || gap >= s.cool) pr_run_time[s.res] = '0;
            run = 64'(pr_run_time[s.res]) + s.dur;
            if (run > 64'hFFFF_FFFF) run = 64'hFFFF_FFFF;
            pr_run_time[s.res] = run[31:0];
            pr_limit_hit[s.res] = run >= s.limit;
        end
        pr_last_end[s.res] = fin[31:0];
        pr_active[s.res] = 1;
        if (pr_ivl_count < sstp_pkg::MaxSteps) begin
            pr_ivl_start[pr_ivl_count] = start[31:0];
            pr_ivl_end[pr_ivl_count] = fin[31:0];
            pr_ivl_owner[pr_ivl_count] = s.res;
            pr_ivl_count++;
        end
        p.start = start[31:0];
        p.fin = fin[31:0];
        return p;
    endfunction

    function automatic sstp_pkg::step_t make_step(int slot, int res, logic [31:0] dur,
                                        bit fresh,
                                        logic [31:0] settle = 0, logic [31:0] cool = 0,
                                        logic [31:0] limit = 0, logic [7:0] mask = 0,
                                        logic [8:0] da = NO_DEP, logic [8:0] db = NO_DEP);
        sstp_pkg::step_t s;
        s.slot = SLW'(slot);
        s.res = RW'(res);
        s.dur = dur;
        s.dep_a = da;
        s.dep_b = db;
        s.dep_c = NO_DEP;
        s.dep_d = NO_DEP;
        s.settle = settle;
        s.cool = cool;
        s.limit = limit;
        s.mask = mask;
        s.new_sched = fresh;
        return s;
    endfunction

    task automatic send_step(sstp_pkg::step_t s);
        placement_t p;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {s.new_sched, s.mask, s.limit, s.cool, s.settle, s.dep_d,
                    s.dep_c, s.dep_b, s.dep_a, s.dur, s.res, s.slot};
        do @(posedge aclk); while (!s_tready);
        p = place_step(s);
        pending_placements = {pending_placements, p};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_step_count(logic [8:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pr_step_count = v;
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= calm || $urandom_range(99) >= 26;
        end
    end

    always @(posedge aclk) begin
        placement_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_placements.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], 0);
            end else begin
                want = pending_placements.pop_front();
                if (m_tdata[7:0] != want.slot) report_mismatch("out_slot", m_tdata[7:0], want.slot);
                if (m_tdata[39:8] != want.start)
                    report_mismatch("start_time", m_tdata[39:8], want.start);
                if (m_tdata[71:40] != want.fin)
                    report_mismatch("end_time", m_tdata[71:40], want.fin);
                if (m_tdata[73:72] != want.status)
                    report_mismatch("status", m_tdata[73:72], want.status);
            end
        end
    end

    task automatic test_directed();
        send_step(make_step(0, 0, 100, 1));
        send_step(make_step(1, 0, 50, 0, 10));
        send_step(make_step(2, 1, 0, 0, 0, 0, 0, 0, 1, 9'd511));
        send_step(make_step(3, 1, 80, 0, 0, 1000, 100, 0, 9'd300, 9'd5));
        send_step(make_step(4, 1, 80, 0, 0, 1000, 100, 0, 3));
        send_step(make_step(5, 1, 30, 0, 0, 1000, 100, 0));
        send_step(make_step(6, 2, 500, 0, 0, 0, 0, 8'hFF));
        send_step(make_step(7, 7, 20, 0, 0, 0, 32'hFFFF_FFFF, 8'h86, 6));
        send_step(make_step(8, 3, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 7));
        send_step(make_step(9, 3, 1, 0));
        send_step(make_step(255, 7, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            8'hFF, 9'd255, 9'd256));
        send_step(make_step(254, 6, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 255));
        write_step_count(9'd0);
        send_step(make_step(10, 1, 10, 1));
        send_step(make_step(11, 2, 10, 0, 0, 0, 0, 0, 10));
        send_step(make_step(12, 0, 10, 0, 0, 0, 0, 8'h06));
        send_step(make_step(13, 0, 10, 0));
        send_step(make_step(14, 4, 10, 1));
        write_step_count(9'd1);
        send_step(make_step(15, 1, 10, 1));
        send_step(make_step(16, 2, 10, 0, 0, 0, 0, 0, 15));
        send_step(make_step(17, 0, 10, 0, 0, 0, 0, 8'h06));
        write_step_count(9'd511);
        drain();
    endtask

    task automatic test_store_full();
        write_step_count(9'd256);
        calm = 1'b1;
        for (int i = 0; i < 262; i++)
            send_step(make_step(i % 256, $urandom_range(7), $urandom_range(50), i == 0,
                                $urandom_range(3), 0, 0, 0, DW'($urandom_range(511))));
        calm = 1'b0;
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++)
            send_step(make_step(i, i % 8, 40, i == 0, 0, 0, 0, 8'h0F));
        drain();
    endtask

    task automatic test_random(int count);
        sstp_pkg::step_t s;
        int              sent, len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) write_step_count($urandom_range(3) == 0 ?
                                                         9'($urandom_range(511)) : 9'd256);
            calm = (sent > count / 3 && sent < count / 2);
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
                s = make_step($urandom_range(255), $urandom_range(7),
                              $urandom_range(7) == 0 ? $urandom : $urandom_range(1000),
                              k == 0 ? 1'b1 : ($urandom_range(19) == 0));
                s.dep_a = $urandom_range(5) == 0 ? DW'($urandom_range(511))
                                                 : DW'($urandom_range(255));
                s.dep_b = $urandom_range(1) ? NO_DEP : DW'($urandom_range(511));
                s.dep_c = $urandom_range(3) ? NO_DEP : DW'($urandom_range(511));
                s.dep_d = $urandom_range(3) ? NO_DEP : DW'($urandom_range(511));
                s.settle = $urandom_range(9) == 0 ? $urandom : $urandom_range(100);
                s.cool = $urandom_range(9) == 0 ? $urandom : $urandom_range(2000);
                s.limit = $urandom_range(2) == 0 ? 0 :
                          ($urandom_range(9) == 0 ? $urandom : $urandom_range(1500));
                s.mask = MW'($urandom_range(255));
                send_step(s);
                sent++;
            end
        end
        calm = 1'b0;
        drain();
    endtask

    initial begin
        pr_step_count = 256;
        wipe_schedule();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_store_full();
        test_random(1000);
        repeat (50) @(posedge aclk);
        if (pending_placements.size() != 0)
            report_mismatch("results missing", 64'(pending_placements.size()), 0);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[filelist.f]
design/sstp_pkg.sv
design/sstp_end_store.sv
design/sstp_ivl_store.sv
design/step_start_time_placer_core.sv
verif/testbench.sv
